[rtl/i2c_master_byte_engine_assert.svh]
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge.
`define ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/i2cmbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Field widths, request kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int HALF_W  = 16;
  localparam int LIMIT_W = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_NONE  = 3'd0;
  localparam kind_t KIND_START = 3'd1;
  localparam kind_t KIND_STOP  = 3'd2;
  localparam kind_t KIND_WRITE = 3'd3;
  localparam kind_t KIND_READ  = 3'd4;

  localparam cfg_idx_t REG_HALF_PERIOD = 1'b0;
  localparam cfg_idx_t REG_ACK_LIMIT   = 1'b1;

endpackage

[rtl/i2cmbe_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Request channel (one tick with optional command) and result channel.
// ----------------------------------------------------------------------------
interface i2cmbe_req_if
  import i2cmbe_pkg::*;
();
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t write_data;
  logic  send_nack;
  logic  sda_level;

  modport source (output valid, output kind, output write_data, output send_nack,
                  output sda_level, input ready);
  modport sink (input valid, input kind, input write_data, input send_nack,
                input sda_level, output ready);
endinterface

interface i2cmbe_res_if
  import i2cmbe_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  scl_release;
  logic  sda_release;
  logic  busy_res;
  logic  done_res;
  byte_t read_data;
  logic  ack_status;

  modport source (output valid, output scl_release, output sda_release,
                  output busy_res, output done_res, output read_data,
                  output ack_status, input ready);
  modport sink (input valid, input scl_release, input sda_release, input busy_res,
                input done_res, input read_data, input ack_status, output ready);
endinterface

[rtl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain SCL/SDA sequencer for start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
// Each request is one bus tick; while cmd.ready is high, one request is taken
// per clock cycle and its result appears in the output register on the next
// cycle. A request is taken whenever the output register is empty or is being
// emptied in the same cycle, so requests stall only on a full, unread result
// register. Bus timing is counted in requests, in units of half_period_ticks.
`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine
  import i2cmbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  i2cmbe_req_if.sink           cmd,
  i2cmbe_res_if.source         res
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_ST1       = 5'd1;
  localparam logic [4:0] PH_ST2       = 5'd2;
  localparam logic [4:0] PH_ST3       = 5'd3;
  localparam logic [4:0] PH_SP1       = 5'd4;
  localparam logic [4:0] PH_SP2       = 5'd5;
  localparam logic [4:0] PH_SP3       = 5'd6;
  localparam logic [4:0] PH_WR_LO     = 5'd7;
  localparam logic [4:0] PH_WR_HI     = 5'd8;
  localparam logic [4:0] PH_WR_GAP    = 5'd9;
  localparam logic [4:0] PH_AK_LO     = 5'd10;
  localparam logic [4:0] PH_AK_SAMPLE = 5'd11;
  localparam logic [4:0] PH_AK_RETRY  = 5'd12;
  localparam logic [4:0] PH_RD_LO     = 5'd13;
  localparam logic [4:0] PH_RD_HI     = 5'd14;
  localparam logic [4:0] PH_PA_LO     = 5'd15;
  localparam logic [4:0] PH_PA_HI     = 5'd16;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  logic [HALF_W-1:0]  half_period_ticks;
  logic [LIMIT_W-1:0] ack_sample_limit;

  logic [4:0]         phase, phase_next;
  logic [HALF_W:0]    tick_counter, tick_counter_next;
  logic [3:0]         bit_counter, bit_counter_next;
  byte_t              shift_byte, shift_byte_next;
  logic [LIMIT_W-1:0] ack_tries, ack_tries_next;
  logic               nack_to_send, nack_to_send_next;
  logic               scl_drive, scl_drive_next;
  logic               sda_drive, sda_drive_next;
  logic               last_ack, last_ack_next;
  byte_t              read_hold, read_hold_next;
  logic               done_next;

  logic               out_valid;
  logic               take;
  logic [HALF_W:0]    half_len;
  logic [HALF_W:0]    full_len;
  logic [HALF_W:0]    tick_dec;
  logic [3:0]         bit_inc;
  logic [LIMIT_W-1:0] tries_inc;

  assign cmd.ready = !out_valid || res.ready;
  assign take      = cmd.valid && cmd.ready;

  assign half_len  = (half_period_ticks == '0) ? (HALF_W+1)'(1)
                                               : {1'b0, half_period_ticks};
  assign full_len  = {half_len[HALF_W-1:0], 1'b0};
  assign tick_dec  = (tick_counter != '0) ? tick_counter - (HALF_W+1)'(1) : '0;
  assign bit_inc   = bit_counter + 4'd1;
  assign tries_inc = ack_tries + LIMIT_W'(1);

  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_counter_next  = bit_counter;
    shift_byte_next   = shift_byte;
    ack_tries_next    = ack_tries;
    nack_to_send_next = nack_to_send;
    scl_drive_next    = scl_drive;
    sda_drive_next    = sda_drive;
    last_ack_next     = last_ack;
    read_hold_next    = read_hold;
    done_next         = 1'b0;
    if (phase == PH_IDLE) begin
      case (cmd.kind)
        KIND_START: begin
          sda_drive_next    = 1'b1;
          tick_counter_next = half_len;
          phase_next        = PH_ST1;
        end
        KIND_STOP: begin
          scl_drive_next    = 1'b0;
          sda_drive_next    = 1'b0;
          tick_counter_next = half_len;
          phase_next        = PH_SP1;
        end
        KIND_WRITE: begin
          bit_counter_next  = 4'd0;
          scl_drive_next    = 1'b0;
          sda_drive_next    = cmd.write_data[BYTE_W-1];
          shift_byte_next   = {cmd.write_data[BYTE_W-2:0], 1'b0};
          tick_counter_next = half_len;
          phase_next        = PH_WR_LO;
        end
        KIND_READ: begin
          shift_byte_next   = '0;
          bit_counter_next  = 4'd0;
          nack_to_send_next = cmd.send_nack;
          sda_drive_next    = 1'b1;
          scl_drive_next    = 1'b0;
          tick_counter_next = half_len;
          phase_next        = PH_RD_LO;
        end
        default: begin
        end
      endcase
    end else begin
      tick_counter_next = tick_dec;
      if (tick_dec == '0) begin
        case (phase)
          PH_ST1: begin
            scl_drive_next    = 1'b1;
            tick_counter_next = full_len;
            phase_next        = PH_ST2;
          end
          PH_ST2: begin
            sda_drive_next    = 1'b0;
            tick_counter_next = full_len;
            phase_next        = PH_ST3;
          end
          PH_ST3: begin
            scl_drive_next = 1'b0;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
          end
          PH_SP1: begin
            scl_drive_next    = 1'b1;
            tick_counter_next = full_len;
            phase_next        = PH_SP2;
          end
          PH_SP2: begin
            sda_drive_next    = 1'b1;
            tick_counter_next = full_len;
            phase_next        = PH_SP3;
          end
          PH_SP3: begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
          PH_WR_LO: begin
            scl_drive_next    = 1'b1;
            tick_counter_next = half_len;
            phase_next        = PH_WR_HI;
          end
          PH_WR_HI: begin
            scl_drive_next    = 1'b0;
            tick_counter_next = half_len;
            phase_next        = PH_WR_GAP;
          end
          PH_WR_GAP: begin
            bit_counter_next  = bit_inc;
            tick_counter_next = half_len;
            if (bit_inc < BITS_PER_BYTE) begin
              scl_drive_next  = 1'b0;
              sda_drive_next  = shift_byte[BYTE_W-1];
              shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
              phase_next      = PH_WR_LO;
            end else begin
              sda_drive_next = 1'b1;
              ack_tries_next = '0;
              phase_next     = PH_AK_LO;
            end
          end
          PH_AK_LO: begin
            scl_drive_next    = 1'b1;
            tick_counter_next = half_len;
            phase_next        = PH_AK_SAMPLE;
          end
          PH_AK_SAMPLE, PH_AK_RETRY: begin
            if (phase == PH_AK_RETRY) begin
              ack_tries_next = tries_inc;
            end
            if ((phase == PH_AK_RETRY) && (tries_inc >= ack_sample_limit)) begin
              last_ack_next     = 1'b1;
              scl_drive_next    = 1'b0;
              sda_drive_next    = 1'b0;
              tick_counter_next = half_len;
              phase_next        = PH_SP1;
            end else if (!cmd.sda_level) begin
              sda_drive_next = 1'b1;
              scl_drive_next = 1'b0;
              last_ack_next  = 1'b0;
              phase_next     = PH_IDLE;
              done_next      = 1'b1;
            end else begin
              tick_counter_next = half_len;
              phase_next        = PH_AK_RETRY;
            end
          end
          PH_RD_LO: begin
            scl_drive_next    = 1'b1;
            shift_byte_next   = {shift_byte[BYTE_W-2:0], cmd.sda_level};
            tick_counter_next = half_len;
            phase_next        = PH_RD_HI;
          end
          PH_RD_HI: begin
            bit_counter_next  = bit_inc;
            scl_drive_next    = 1'b0;
            tick_counter_next = half_len;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_next = PH_RD_LO;
            end else begin
              sda_drive_next = nack_to_send;
              phase_next     = PH_PA_LO;
            end
          end
          PH_PA_LO: begin
            scl_drive_next    = 1'b1;
            tick_counter_next = half_len;
            phase_next        = PH_PA_HI;
          end
          PH_PA_HI: begin
            scl_drive_next = 1'b0;
            read_hold_next = shift_byte;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_W'(250);
      ack_sample_limit  <= LIMIT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_data[HALF_W-1:0];
        REG_ACK_LIMIT:   ack_sample_limit  <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      bit_counter  <= '0;
      shift_byte   <= '0;
      ack_tries    <= '0;
      nack_to_send <= 1'b0;
      scl_drive    <= 1'b1;
      sda_drive    <= 1'b1;
      last_ack     <= 1'b0;
      read_hold    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_counter  <= bit_counter_next;
      shift_byte   <= shift_byte_next;
      ack_tries    <= ack_tries_next;
      nack_to_send <= nack_to_send_next;
      scl_drive    <= scl_drive_next;
      sda_drive    <= sda_drive_next;
      last_ack     <= last_ack_next;
      read_hold    <= read_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.scl_release <= scl_drive_next;
      res.sda_release <= sda_drive_next;
      res.busy_res    <= (phase_next != PH_IDLE);
      res.done_res    <= done_next;
      res.read_data   <= read_hold_next;
      res.ack_status  <= last_ack_next;
    end
  end

  assign res.valid = out_valid;

  `ASSERT_HOLDS(a_idle_no_count, (phase != PH_IDLE) || (tick_counter == '0), "idle with count")
  `ASSERT_HOLDS(a_bit_range, bit_counter <= BITS_PER_BYTE, "bit counter past byte")
  `ASSERT_HOLDS(a_done_not_busy, !(out_valid && res.done_res && res.busy_res), "done while busy")
  `ASSERT_NEXT(a_start_enters, take && (phase == PH_IDLE) && (cmd.kind == KIND_START), phase == PH_ST1, "start not taken")

endmodule
